// ----- rtl/tvf_pkg.sv -----
// shared types and constants for the text view byte filter
`timescale 1ns / 1ps
`default_nettype none

package tvf_pkg;

    localparam int NUMBER_DIGITS_DEF = 6;

    // configuration register indexes
    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] CFG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [CFG_W-1:0] CFG_NUMBER_ALL       = 3'd1;
    localparam logic [CFG_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_W-1:0] CFG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_W-1:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    // fixed string placed between the line number and the byte itself
    localparam logic [2:0] SEG_NONE      = 3'd0;
    localparam logic [2:0] SEG_CARET_I   = 3'd1;
    localparam logic [2:0] SEG_END       = 3'd2;
    localparam logic [2:0] SEG_END_EMPTY = 3'd3;
    localparam logic [2:0] SEG_CARET     = 3'd4;
    localparam logic [2:0] SEG_META      = 3'd5;

    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_NL       = 8'd10;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_DOLLAR   = 8'd36;
    localparam logic [7:0] CH_DASH     = 8'd45;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] CH_I        = 8'd73;
    localparam logic [7:0] CH_M        = 8'd77;
    localparam logic [7:0] CH_CARET    = 8'd94;
    localparam logic [7:0] CH_DEL      = 8'd127;
    localparam logic [7:0] CH_META_LO  = 8'd128;
    localparam logic [7:0] CH_HIGH_LO  = 8'd160;
    localparam logic [7:0] CTRL_OFFSET = 8'd64;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // rendering job for one input word
    typedef struct packed {
        logic       num_en;
        logic [2:0] seg;
        logic       chr_en;
        logic [7:0] chr;
    } t_desc;

endpackage

`default_nettype wire

// ----- rtl/tvf_render.sv -----
// line state and decode of one input word into a rendering job
`timescale 1ns / 1ps
`default_nettype none

module tvf_render #(
    parameter int NUMBER_DIGITS = tvf_pkg::NUMBER_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic                         i_action,
    input  wire logic [7:0]                   i_in_byte,
    input  wire tvf_pkg::t_cfg                i_cfg,
    output logic                              o_desc_valid,
    output tvf_pkg::t_desc                    o_desc,
    output logic [4*NUMBER_DIGITS-1:0]        o_digits
);
    import tvf_pkg::*;

    localparam int LINE_W = 4 * NUMBER_DIGITS;

    logic              r_prev_nl, n_prev_nl;
    logic [1:0]        r_blank_run, n_blank_run;
    logic [LINE_W-1:0] r_line, n_line;
    logic              r_col_nz, n_col_nz;

    logic              is_nl, is_tab, is_low, is_meta, is_del;
    logic              sq_cond, squeezed, num_en, np, tab_show;
    logic [1:0]        blank_inc;
    logic [LINE_W-1:0] line_inc;
    logic              carry, all_nine;
    logic [2:0]        seg;
    logic [7:0]        chr;

    assign is_nl   = (i_in_byte == CH_NL);
    assign is_tab  = (i_in_byte == CH_TAB);
    assign is_low  = (i_in_byte < CH_SPACE);
    assign is_meta = (i_in_byte >= CH_META_LO) && (i_in_byte < CH_HIGH_LO);
    assign is_del  = (i_in_byte == CH_DEL);

    assign sq_cond   = r_prev_nl && is_nl && i_cfg.squeeze_blank;
    assign blank_inc = (r_blank_run < 2'd2) ? r_blank_run + 2'd1 : r_blank_run;
    assign squeezed  = sq_cond && (blank_inc > 2'd1);
    assign num_en    = r_prev_nl && ((i_cfg.number_nonblank && !is_nl) ||
                                     (i_cfg.number_all && !i_cfg.number_nonblank));
    assign np        = i_cfg.show_nonprinting && !is_nl && !is_tab;
    assign tab_show  = i_cfg.show_tabs && is_tab;

    always_comb begin
        seg = SEG_NONE;
        chr = i_in_byte;
        if (tab_show) begin
            seg = SEG_CARET_I;
        end else if (i_cfg.show_ends && is_nl) begin
            seg = (i_cfg.number_nonblank && !r_col_nz) ? SEG_END_EMPTY : SEG_END;
        end else if (np && is_low) begin
            seg = SEG_CARET;
            chr = i_in_byte + CTRL_OFFSET;
        end else if (np && is_meta) begin
            seg = SEG_META;
            chr = i_in_byte - CTRL_OFFSET;
        end else if (np && is_del) begin
            seg = SEG_CARET;
            chr = i_in_byte - CTRL_OFFSET;
        end
    end

    // bcd increment, held at all nines
    always_comb begin
        line_inc = r_line;
        carry    = 1'b1;
        all_nine = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            all_nine = all_nine && (r_line[4*i +: 4] == 4'd9);
            if (carry) begin
                if (r_line[4*i +: 4] == 4'd9) begin
                    line_inc[4*i +: 4] = 4'd0;
                end else begin
                    line_inc[4*i +: 4] = r_line[4*i +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_prev_nl   = r_prev_nl;
        n_blank_run = r_blank_run;
        n_line      = r_line;
        n_col_nz    = r_col_nz;
        if (i_accept) begin
            if (i_action) begin
                n_prev_nl = 1'b1;
                n_line    = LINE_W'(1);
                n_col_nz  = 1'b0;
            end else begin
                n_prev_nl   = is_nl;
                n_blank_run = sq_cond ? blank_inc : 2'd0;
                if (!squeezed) begin
                    n_col_nz = !is_nl;
                    if (num_en && !all_nine) begin
                        n_line = line_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_nl   <= 1'b1;
            r_blank_run <= 2'd0;
            r_line      <= LINE_W'(1);
            r_col_nz    <= 1'b0;
        end else begin
            r_prev_nl   <= n_prev_nl;
            r_blank_run <= n_blank_run;
            r_line      <= n_line;
            r_col_nz    <= n_col_nz;
        end
    end

    assign o_desc_valid  = !i_action && !squeezed;
    assign o_desc.num_en = num_en;
    assign o_desc.seg    = seg;
    assign o_desc.chr_en = !tab_show;
    assign o_desc.chr    = chr;
    assign o_digits      = r_line;

endmodule

`default_nettype wire

// ----- rtl/tvf_emit.sv -----
// job register and byte emitter feeding the output register
`timescale 1ns / 1ps
`default_nettype none

module tvf_emit #(
    parameter int NUMBER_DIGITS = tvf_pkg::NUMBER_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic                         i_desc_valid,
    input  wire tvf_pkg::t_desc               i_desc,
    input  wire logic [4*NUMBER_DIGITS-1:0]   i_digits,
    input  wire logic                         i_out_stall,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output logic [7:0]                        o_out_byte,
    output logic                              o_last
);
    import tvf_pkg::*;

    localparam int LINE_W = 4 * NUMBER_DIGITS;
    localparam int POS_W  = $clog2(NUMBER_DIGITS + 6);

    logic              r_job_valid;
    t_desc             r_job;
    logic [LINE_W-1:0] r_job_digits;
    logic [POS_W-1:0]  r_pos;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic [7:0]        num_chars [NUMBER_DIGITS];
    logic              seen_nz;
    logic [POS_W-1:0]  len_a, len_b, total, offs;
    logic [7:0]        num_byte, seg_byte, sel_byte;
    logic              is_last, out_load, emit, take_job;

    // digit characters with leading zeros shown as spaces
    always_comb begin
        seen_nz = 1'b0;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            seen_nz = seen_nz || (r_job_digits[4*(NUMBER_DIGITS-1-i) +: 4] != 4'd0);
            if (!seen_nz && (i != NUMBER_DIGITS - 1)) begin
                num_chars[i] = CH_SPACE;
            end else begin
                num_chars[i] = CH_ZERO + {4'd0, r_job_digits[4*(NUMBER_DIGITS-1-i) +: 4]};
            end
        end
    end

    always_comb begin
        num_byte = CH_TAB;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (r_pos == POS_W'(i)) begin
                num_byte = num_chars[i];
            end
        end
    end

    assign len_a = r_job.num_en ? POS_W'(NUMBER_DIGITS + 1) : '0;

    always_comb begin
        case (r_job.seg)
            SEG_NONE:      len_b = '0;
            SEG_CARET_I:   len_b = POS_W'(2);
            SEG_END:       len_b = POS_W'(1);
            SEG_END_EMPTY: len_b = POS_W'(NUMBER_DIGITS + 2);
            SEG_CARET:     len_b = POS_W'(1);
            SEG_META:      len_b = POS_W'(3);
            default:       len_b = '0;
        endcase
    end

    assign total   = len_a + len_b + {{(POS_W-1){1'b0}}, r_job.chr_en};
    assign offs    = r_pos - len_a;
    assign is_last = (r_pos == total - POS_W'(1));

    always_comb begin
        case (r_job.seg)
            SEG_CARET_I:   seg_byte = (offs == '0) ? CH_CARET : CH_I;
            SEG_END:       seg_byte = CH_DOLLAR;
            SEG_END_EMPTY: begin
                if (offs < POS_W'(NUMBER_DIGITS)) begin
                    seg_byte = CH_SPACE;
                end else if (offs == POS_W'(NUMBER_DIGITS)) begin
                    seg_byte = CH_TAB;
                end else begin
                    seg_byte = CH_DOLLAR;
                end
            end
            SEG_CARET:     seg_byte = CH_CARET;
            SEG_META: begin
                if (offs == '0) begin
                    seg_byte = CH_M;
                end else if (offs == POS_W'(1)) begin
                    seg_byte = CH_DASH;
                end else begin
                    seg_byte = CH_CARET;
                end
            end
            default:       seg_byte = CH_SPACE;
        endcase
    end

    always_comb begin
        if (r_pos < len_a) begin
            sel_byte = num_byte;
        end else if (r_pos < len_a + len_b) begin
            sel_byte = seg_byte;
        end else begin
            sel_byte = r_job.chr;
        end
    end

    assign out_load   = !r_out_valid || !i_out_stall;
    assign emit       = r_job_valid && out_load;
    assign o_in_stall = r_job_valid && !(emit && is_last);
    assign take_job   = i_accept && i_desc_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_job) begin
                r_job_valid <= 1'b1;
                r_pos       <= '0;
            end else if (emit) begin
                r_job_valid <= !is_last;
                r_pos       <= r_pos + POS_W'(1);
            end
            if (out_load) begin
                r_out_valid <= r_job_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_job) begin
            r_job        <= i_desc;
            r_job_digits <= i_digits;
        end
        if (emit) begin
            r_out_byte <= sel_byte;
            r_out_last <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/text_view_byte_filter_unit.sv -----
// top level of the text view byte filter
//
//  channel  dir  handshake                        payload
//  in       in   i_in_valid / o_in_stall          i_action, i_in_byte
//  out      out  o_out_valid / i_out_stall        o_out_byte, o_last
//  cfg      in   i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// a word that renders to n bytes stalls the input until its last byte leaves the
// emitter; unless the output stalls, one byte per cycle leaves it for the output
// register and a one-byte word is taken every cycle; its byte passes the job
// register, then the output register; start-of-file and squeezed lines get no job
// synchronous active-low reset: line number 1, previous byte newline, options off
// a stalled output holds its byte; the emitter and then the input stall behind it
`timescale 1ns / 1ps
`default_nettype none

module text_view_byte_filter_unit #(
    parameter int NUMBER_DIGITS = tvf_pkg::NUMBER_DIGITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_action,
    input  wire logic [7:0]                 i_in_byte,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [tvf_pkg::CFG_W-1:0]  i_cfg_index,
    input  wire logic                       i_cfg_data
);
    import tvf_pkg::*;

    t_cfg                       r_cfg;
    logic                       accept;
    logic                       desc_valid;
    t_desc                      desc;
    logic [4*NUMBER_DIGITS-1:0] digits;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_data;
                CFG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg_data;
                CFG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data;
                CFG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data;
                CFG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data;
                CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data;
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    tvf_render #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_render (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_in_byte   (i_in_byte),
        .i_cfg       (r_cfg),
        .o_desc_valid(desc_valid),
        .o_desc      (desc),
        .o_digits    (digits)
    );

    tvf_emit #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_desc_valid(desc_valid),
        .i_desc      (desc),
        .i_digits    (digits),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/tvf_checker.sv -----
// port-level checks for the text view byte filter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module tvf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last
);

    // nothing pending right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or input stall active after reset");

    // a stalled word holds its byte and marker
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled output word changed");

    // bytes of one rendered sequence follow without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid)
        else $error("gap inside a multi-byte sequence");

    // input held off with an empty output register means a byte is on its way
    a_stall_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !o_out_valid |=> o_out_valid)
        else $error("input stalled with no output progress");

endmodule

bind text_view_byte_filter_unit tvf_checker u_tvf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_byte (o_out_byte),
    .o_last     (o_last)
);

`default_nettype wire

// ----- sim/text_view_byte_filter_checker.sv -----
// watches the filter channels, renders each accepted word and compares the output bytes
`timescale 1ns / 1ps
`default_nettype none

module text_view_byte_filter_checker #(
    parameter int DIGITS = tvf_pkg::NUMBER_DIGITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire logic                       i_action,
    input  wire logic [7:0]                 i_in_byte,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic [7:0]                 i_out_byte,
    input  wire logic                       i_last,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_ready,
    input  wire logic [tvf_pkg::CFG_W-1:0]  i_cfg_index,
    input  wire logic                       i_cfg_data,
    output int                              o_mismatches,
    output int                              o_pending
);

    import tvf_pkg::*;

    localparam int LINE_MAX = 10 ** DIGITS - 1;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_rendered;

    t_rendered  rendered_q[$];
    t_cfg       opts;
    logic [7:0] prev_byte;
    logic [1:0] blank_run;
    int         line_no;
    logic       col_busy;

    // renders one accepted word into the expected output bytes
    task automatic render_word(input logic act, input logic [7:0] b);
        logic [7:0] seq[$];
        logic [7:0] digs[DIGITS];
        logic [7:0] prev;
        logic [7:0] c;
        logic       skip;
        logic       squeezed;
        int         v;
        t_rendered  r;
        skip = 1'b0;
        squeezed = 1'b0;
        if (act) begin
            line_no = 1;
            prev_byte = CH_NL;
            col_busy = 1'b0;
        end else begin
            prev = prev_byte;
            c = b;
            prev_byte = c;
            if (prev == CH_NL && c == CH_NL && opts.squeeze_blank) begin
                if (blank_run < 2'd2) blank_run = blank_run + 2'd1;
                if (blank_run > 2'd1) squeezed = 1'b1;
            end else begin
                blank_run = 2'd0;
            end
            if (!squeezed) begin
                if (prev == CH_NL && ((opts.number_nonblank && c != CH_NL) ||
                                      (opts.number_all && !opts.number_nonblank))) begin
                    v = line_no;
                    for (int i = DIGITS - 1; i >= 0; i--) begin
                        if (v != 0 || i == DIGITS - 1) digs[i] = CH_ZERO + 8'(v % 10);
                        else digs[i] = CH_SPACE;
                        v = v / 10;
                    end
                    for (int i = 0; i < DIGITS; i++) seq.push_back(digs[i]);
                    seq.push_back(CH_TAB);
                    if (line_no < LINE_MAX) line_no++;
                end
                if (opts.show_tabs && c == CH_TAB) begin
                    seq.push_back(CH_CARET);
                    seq.push_back(CH_I);
                    skip = 1'b1;
                end
                // with ends shown, an empty line under non-blank numbering keeps the number column
                if (opts.show_ends && opts.number_nonblank && !col_busy && c == CH_NL) begin
                    for (int i = 0; i < DIGITS; i++) seq.push_back(CH_SPACE);
                    seq.push_back(CH_TAB);
                    seq.push_back(CH_DOLLAR);
                end else if (opts.show_ends && c == CH_NL) begin
                    seq.push_back(CH_DOLLAR);
                end
                if (opts.show_nonprinting && c != CH_NL && c != CH_TAB) begin
                    if (c < CH_SPACE) begin
                        seq.push_back(CH_CARET);
                        c = c + CTRL_OFFSET;
                    end else if (c >= CH_META_LO && c < CH_HIGH_LO) begin
                        seq.push_back(CH_M);
                        seq.push_back(CH_DASH);
                        seq.push_back(CH_CARET);
                        c = c - CTRL_OFFSET;
                    end else if (c == CH_DEL) begin
                        seq.push_back(CH_CARET);
                        c = c - CTRL_OFFSET;
                    end
                end
                prev_byte = c;
                if (!skip) seq.push_back(c);
                col_busy = (c != CH_NL);
                for (int k = 0; k < seq.size(); k++) begin
                    r.ch = seq[k];
                    r.fin = (k == seq.size() - 1);
                    rendered_q.push_back(r);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_rendered want;
        if (!i_rst_n) begin
            opts = '0;
            prev_byte = CH_NL;
            blank_run = 2'd0;
            line_no = 1;
            col_busy = 1'b0;
            rendered_q.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUMBER_NONBLANK:  opts.number_nonblank = i_cfg_data;
                    CFG_NUMBER_ALL:       opts.number_all = i_cfg_data;
                    CFG_SQUEEZE_BLANK:    opts.squeeze_blank = i_cfg_data;
                    CFG_SHOW_ENDS:        opts.show_ends = i_cfg_data;
                    CFG_SHOW_TABS:        opts.show_tabs = i_cfg_data;
                    CFG_SHOW_NONPRINTING: opts.show_nonprinting = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) render_word(i_action, i_in_byte);
            if (i_out_valid && !i_out_stall) begin
                if (rendered_q.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("unexpected output word: byte %0d last %0b at %0t",
                                 i_out_byte, i_last, $realtime);
                    o_mismatches++;
                end else begin
                    want = rendered_q.pop_front();
                    if (i_out_byte !== want.ch || i_last !== want.fin) begin
                        if (o_mismatches < 10)
                            $display({"mismatch at %0t: expected byte %0d last %0b, ",
                                      "got byte %0d last %0b"},
                                     $realtime, want.ch, want.fin, i_out_byte, i_last);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = rendered_q.size();
    end

endmodule

`default_nettype wire

// ----- sim/text_view_byte_filter_unit_tb.sv -----
// stimulus and verdict for the text view byte filter, checked by a separate watcher
`timescale 1ns / 1ps
`default_nettype none

module text_view_byte_filter_unit_tb;

    import tvf_pkg::*;

    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 26;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              action = 1'b0;
    logic [7:0]        in_byte = 8'd0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        out_byte;
    logic              out_last;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_index = '0;
    logic              cfg_data = 1'b0;
    int                mismatches;
    int                pending;
    int                src_idle_pct = 16;
    int                sink_stall_pct = 67;

    always #5 clk = ~clk;

    text_view_byte_filter_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_action    (action),
        .i_in_byte   (in_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_byte  (out_byte),
        .o_last      (out_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    text_view_byte_filter_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_action     (action),
        .i_in_byte    (in_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_byte   (out_byte),
        .i_last       (out_last),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    task automatic send_word(input logic act, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        in_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_options(input t_cfg o);
        write_reg(CFG_NUMBER_NONBLANK, o.number_nonblank);
        write_reg(CFG_NUMBER_ALL, o.number_all);
        write_reg(CFG_SQUEEZE_BLANK, o.squeeze_blank);
        write_reg(CFG_SHOW_ENDS, o.show_ends);
        write_reg(CFG_SHOW_TABS, o.show_tabs);
        write_reg(CFG_SHOW_NONPRINTING, o.show_nonprinting);
    endtask

    // drains the output and lets start-of-file or squeezed words settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        t_cfg       opts;
        logic [5:0] r6;
        logic [7:0] b;
        int         r;
        int         n;
        int         burst;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // index past the last register must be ignored
        write_reg(CFG_SHOW_NONPRINTING + 3'd1, 1'b1);
        write_reg(CFG_SHOW_NONPRINTING + 3'd2, 1'b1);
        opts = '1;
        write_options(opts);
        send_word(1'b1, 8'hFF);
        send_word(1'b0, "A");
        send_word(1'b0, CH_NL);
        send_word(1'b0, CH_NL);
        send_word(1'b0, CH_NL);
        send_word(1'b0, CH_NL);
        send_word(1'b0, 8'd0);
        send_word(1'b0, 8'd31);
        send_word(1'b0, CH_TAB);
        send_word(1'b0, CH_DEL);
        send_word(1'b0, 8'd128);
        send_word(1'b0, 8'd159);
        send_word(1'b0, 8'd160);
        send_word(1'b0, 8'd255);
        send_word(1'b0, CH_NL);
        send_word(1'b0, CH_SPACE);
        send_word(1'b0, 8'd126);
        send_word(1'b0, CH_NL);
        wait_idle();

        // all-lines numbering, tab passes through despite caret notation
        opts = '0;
        opts.number_all = 1'b1;
        opts.show_ends = 1'b1;
        opts.show_nonprinting = 1'b1;
        write_options(opts);
        send_word(1'b0, CH_TAB);
        send_word(1'b0, CH_NL);
        send_word(1'b0, CH_NL);
        send_word(1'b1, 8'h00);
        send_word(1'b0, CH_NL);
        send_word(1'b0, "z");
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 4) begin
                src_idle_pct = 16;
                sink_stall_pct = 67;
            end else if (ph < 7) begin
                src_idle_pct = 67;
                sink_stall_pct = 16;
            end else begin
                src_idle_pct = 0;
                sink_stall_pct = 0;
            end
            if (ph == 0) begin
                opts = '0;
            end else if (ph == 1) begin
                opts = '1;
            end else begin
                r6 = 6'($urandom);
                opts = r6;
            end
            if ($urandom_range(3) == 0)
                write_reg(CFG_SHOW_NONPRINTING + 3'd1 + 3'($urandom_range(1)), 1'($urandom));
            write_options(opts);
            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                r = $urandom_range(99);
                if (r < 6) begin
                    // run of empty lines
                    burst = $urandom_range(4, 2);
                    repeat (burst) send_word(1'b0, CH_NL);
                    n += burst;
                end else begin
                    if (r < 9) begin
                        b = 8'($urandom);
                        send_word(1'b1, b);
                    end else begin
                        if (r < 24) b = CH_NL;
                        else if (r < 32) b = CH_TAB;
                        else if (r < 42) b = 8'($urandom_range(31, 0));
                        else if (r < 49) b = 8'($urandom_range(159, 127));
                        else if (r < 58) b = 8'($urandom_range(255, 160));
                        else b = 8'($urandom_range(126, 32));
                        send_word(1'b0, b);
                    end
                    n++;
                end
            end
            wait_idle();
        end

        repeat (16) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
